// ===== rtl/ut2cal_pkg.sv =====
// ----------------------------------------------------------------------------
// ut2cal_pkg: shared types, constants and tables for the unix time converter
// Holds channel payload types, controller/datapath command structs, divider
// op codes and the calendar helper functions.
// ----------------------------------------------------------------------------
package ut2cal_pkg;

   // channel payloads
   typedef struct packed {
      logic [31:0] epoch_seconds;
   } req_type;

   typedef struct packed {
      logic [11:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_of_month;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
      logic [2:0]  weekday_out;
      logic [5:0]  week_number;
   } rsp_type;

   // constant divider operations
   localparam logic [2:0] DIV_DAY  = 3'd0;
   localparam logic [2:0] DIV_HOUR = 3'd1;
   localparam logic [2:0] DIV_MIN  = 3'd2;
   localparam logic [2:0] DIV_WDAY = 3'd3;
   localparam logic [2:0] DIV_WEEK = 3'd4;

   localparam logic [16:0] SecsPerDay     = 17'd86400;
   localparam logic [16:0] SecsPerHour    = 17'd3600;
   localparam logic [16:0] SecsPerMinute  = 17'd60;
   localparam logic [16:0] DaysPerWeek    = 17'd7;
   localparam logic [11:0] FirstYear      = 12'd1970;
   localparam logic [15:0] ThursdayOffset = 16'd4;
   localparam logic [8:0]  WeekBias       = 9'd11;
   localparam logic [2:0]  Sunday         = 3'd7;

   typedef struct packed {
      logic       div_start;
      logic [2:0] start_op;
      logic       div_step;
      logic       div_capture;
      logic [2:0] op;
      logic       year_step;
      logic       month_begin;
      logic       month_step;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic year_found;
      logic month_found;
   } status_type;

   // gregorian rule over the reachable years 1970..2106
   function automatic logic leap_year(input logic [11:0] year);
      return (year[1:0] == 2'd0) && (year != 12'd2100);
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2: len = leap ? 5'd29 : 5'd28;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/ut2cal_if.sv =====
// ----------------------------------------------------------------------------
// ut2cal channel interfaces
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface ut2cal_req_if;
   import ut2cal_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ut2cal_rsp_if;
   import ut2cal_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/unix_time_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// unix_time_to_calendar_date: unix seconds to UTC calendar date and time
// Converts a 32-bit seconds count into year, month, day, time of day,
// weekday and an uncorrected week number.
//
//   channel    role     handshake     payload
//   req_chan   input    valid/ready   epoch_seconds
//   rsp_chan   output   valid/ready   date, time, weekday, week number
//
// One item at a time: the conversion time is set by the year walk (one year per
// cycle, up to 136) and the month walk (up to 11); each constant division runs
// multiply, quotient and remainder steps; hours to weekday overlap the year walk.
// Reset is synchronous and clears the controller only.
// A new request is taken while a result waits; a stalled output holds the
// finished item back at the end of its conversion.
// ----------------------------------------------------------------------------
module unix_time_to_calendar_date (
   input  logic         clock,
   input  logic         reset,
   ut2cal_req_if.sink   req_chan,
   ut2cal_rsp_if.source rsp_chan
);
   import ut2cal_pkg::*;

   cmd_type    cmd;
   status_type status;

   ut2cal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ut2cal_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_chan.payload),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_chan.payload)
   );

endmodule

// ===== rtl/ut2cal_ctrl.sv =====
// ----------------------------------------------------------------------------
// ut2cal_ctrl: sequencing controller
// Runs the divider op chain and the year/month walk in parallel and hands
// the finished result to the output register.
// ----------------------------------------------------------------------------
module ut2cal_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ut2cal_pkg::status_type status,
   output ut2cal_pkg::cmd_type    cmd
);
   import ut2cal_pkg::*;

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_RUN  = 2'd1;
   localparam logic [1:0] D_WAIT = 2'd2;
   localparam logic [1:0] D_FIN  = 2'd3;

   localparam logic [1:0] C_IDLE  = 2'd0;
   localparam logic [1:0] C_YEAR  = 2'd1;
   localparam logic [1:0] C_MONTH = 2'd2;
   localparam logic [1:0] C_DONE  = 2'd3;

   logic [1:0] div_state_ff, div_state_in;
   logic [1:0] cal_state_ff, cal_state_in;
   logic [2:0] op_ff, op_in;
   logic       out_valid_ff, out_valid_in;

   assign req_ready = (div_state_ff == D_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      div_state_in = div_state_ff;
      cal_state_in = cal_state_ff;
      op_in        = op_ff;
      cmd          = '0;
      cmd.op       = op_ff;

      // calendar walk
      case (cal_state_ff)
         C_YEAR: begin
            if (status.year_found) begin
               cmd.month_begin = 1'b1;
               cal_state_in    = C_MONTH;
            end else begin
               cmd.year_step = 1'b1;
            end
         end
         C_MONTH: begin
            if (status.month_found) begin
               cal_state_in = C_DONE;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         default: ;
      endcase

      // divider op chain
      case (div_state_ff)
         D_IDLE: begin
            if (req_valid) begin
               cmd.div_start = 1'b1;
               cmd.start_op  = DIV_DAY;
               op_in         = DIV_DAY;
               div_state_in  = D_RUN;
            end
         end
         D_RUN: begin
            if (!status.div_done) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.div_capture = 1'b1;
               case (op_ff)
                  DIV_DAY: begin
                     cmd.div_start = 1'b1;
                     cmd.start_op  = DIV_HOUR;
                     op_in         = DIV_HOUR;
                     cal_state_in  = C_YEAR;
                  end
                  DIV_HOUR: begin
                     cmd.div_start = 1'b1;
                     cmd.start_op  = DIV_MIN;
                     op_in         = DIV_MIN;
                  end
                  DIV_MIN: begin
                     cmd.div_start = 1'b1;
                     cmd.start_op  = DIV_WDAY;
                     op_in         = DIV_WDAY;
                  end
                  DIV_WDAY: div_state_in = D_WAIT;
                  default:  div_state_in = D_FIN;
               endcase
            end
         end
         D_WAIT: begin
            // week needs day of year, known once the year walk is over
            if (cal_state_ff != C_YEAR) begin
               cmd.div_start = 1'b1;
               cmd.start_op  = DIV_WEEK;
               op_in         = DIV_WEEK;
               div_state_in  = D_RUN;
            end
         end
         default: begin
            if ((cal_state_ff == C_DONE) && (!out_valid_ff || rsp_ready)) begin
               cmd.publish  = 1'b1;
               div_state_in = D_IDLE;
               cal_state_in = C_IDLE;
            end
         end
      endcase

      if (cmd.publish) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_state_ff <= D_IDLE;
         cal_state_ff <= C_IDLE;
         op_ff        <= DIV_DAY;
         out_valid_ff <= 1'b0;
      end else begin
         div_state_ff <= div_state_in;
         cal_state_ff <= cal_state_in;
         op_ff        <= op_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_cal_idle_when_free: assert property (@(posedge clock) disable iff (reset)
      (div_state_ff == D_IDLE) |-> (cal_state_ff == C_IDLE))
      else $error("calendar walk active while controller idle");

   a_week_after_year: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_start && (cmd.start_op == DIV_WEEK)) |-> (cal_state_ff != C_YEAR))
      else $error("week division started before day of year known");

   a_accept_starts_day: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ((div_state_ff == D_RUN) && (op_ff == DIV_DAY)))
      else $error("transfer did not start the day division");

endmodule

// ===== rtl/ut2cal_dp.sv =====
// ----------------------------------------------------------------------------
// ut2cal_dp: conversion datapath
// Reciprocal-multiply constant divider, year/month subtraction walk and the
// output register.
// ----------------------------------------------------------------------------
module ut2cal_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  ut2cal_pkg::req_type    req_data,
   input  ut2cal_pkg::cmd_type    cmd,
   output ut2cal_pkg::status_type status,
   output ut2cal_pkg::rsp_type    rsp_data
);
   import ut2cal_pkg::*;

   // reciprocals rounded up, exact over each dividend range
   localparam logic [25:0] RecipDay  = 26'd50903317;  // 2^35 / 675
   localparam logic [25:0] RecipHour = 26'd9321;      // 2^21 / 225
   localparam logic [25:0] RecipMin  = 26'd1093;      // 2^14 / 15
   localparam logic [25:0] RecipWeek = 26'd74899;     // 2^19 / 7

   // divider
   logic [31:0] num_ff;
   logic [50:0] prod_ff;
   logic [15:0] quo_ff;
   logic [16:0] rem_ff;
   logic [1:0]  cnt_ff;
   logic [16:0] divisor;
   logic [24:0] mul_a;
   logic [25:0] mul_b;
   logic [15:0] quo_sel;
   logic [16:0] back_prod;

   // results and calendar walk
   logic [15:0] days_ff;
   logic [15:0] cal_days_ff;
   logic [11:0] year_ff;
   logic [3:0]  month_ff;
   logic [8:0]  doy_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [5:0]  second_ff;
   logic [2:0]  wd_ff;
   logic [5:0]  week_ff;
   rsp_type     out_ff;

   logic        leap;
   logic [8:0]  ylen;
   logic [4:0]  mlen;
   logic [15:0] wday_src;
   logic [8:0]  week_src;

   // power-of-two factors of the divisor are shifted off before the multiply
   always_comb begin
      case (cmd.op)
         DIV_DAY: begin
            divisor = SecsPerDay;
            mul_a   = num_ff[31:7];
            mul_b   = RecipDay;
            quo_sel = prod_ff[50:35];
         end
         DIV_HOUR: begin
            divisor = SecsPerHour;
            mul_a   = {12'd0, num_ff[16:4]};
            mul_b   = RecipHour;
            quo_sel = prod_ff[36:21];
         end
         DIV_MIN: begin
            divisor = SecsPerMinute;
            mul_a   = {15'd0, num_ff[11:2]};
            mul_b   = RecipMin;
            quo_sel = prod_ff[29:14];
         end
         default: begin
            divisor = DaysPerWeek;
            mul_a   = {9'd0, num_ff[15:0]};
            mul_b   = RecipWeek;
            quo_sel = prod_ff[34:19];
         end
      endcase
   end

   // remainder always fits 17 bits, so the low product bits are enough
   assign back_prod = {1'b0, quo_ff} * divisor;

   assign leap     = leap_year(year_ff);
   assign ylen     = leap ? 9'd366 : 9'd365;
   assign mlen     = month_len(month_ff, leap);
   assign wday_src = days_ff + ThursdayOffset;
   assign week_src = doy_ff + WeekBias - {6'd0, wd_ff};

   assign status.div_done    = (cnt_ff == 2'd0);
   assign status.year_found  = (cal_days_ff < {7'd0, ylen});
   assign status.month_found = (cal_days_ff < {11'd0, mlen});

   // divider: multiply, take quotient, then remainder by back-multiply
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         cnt_ff <= 2'd3;
         case (cmd.start_op)
            DIV_DAY:  num_ff <= req_data.epoch_seconds;
            DIV_HOUR: num_ff <= {15'd0, rem_ff};
            DIV_MIN:  num_ff <= {20'd0, rem_ff[11:0]};
            DIV_WDAY: num_ff <= {16'd0, wday_src};
            default:  num_ff <= {23'd0, week_src};
         endcase
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - 2'd1;
         case (cnt_ff)
            2'd3:    prod_ff <= {26'd0, mul_a} * {25'd0, mul_b};
            2'd2:    quo_ff  <= quo_sel;
            default: rem_ff  <= num_ff[16:0] - back_prod;
         endcase
      end
   end

   // capture of finished divisions
   always_ff @(posedge clock) begin
      if (cmd.div_capture) begin
         case (cmd.op)
            DIV_DAY:  days_ff   <= quo_ff;
            DIV_HOUR: hour_ff   <= quo_ff[4:0];
            DIV_MIN: begin
               minute_ff <= quo_ff[5:0];
               second_ff <= rem_ff[5:0];
            end
            DIV_WDAY: wd_ff <= (rem_ff[2:0] == 3'd0) ? Sunday : rem_ff[2:0];
            default:  week_ff   <= quo_ff[5:0];
         endcase
      end
   end

   // year and month walk
   always_ff @(posedge clock) begin
      if (cmd.div_capture && (cmd.op == DIV_DAY)) begin
         cal_days_ff <= quo_ff;
         year_ff     <= FirstYear;
      end else if (cmd.year_step) begin
         cal_days_ff <= cal_days_ff - {7'd0, ylen};
         year_ff     <= year_ff + 12'd1;
      end else if (cmd.month_begin) begin
         doy_ff   <= cal_days_ff[8:0];
         month_ff <= 4'd1;
      end else if (cmd.month_step) begin
         cal_days_ff <= cal_days_ff - {11'd0, mlen};
         month_ff    <= month_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_ff.year_out     <= year_ff;
         out_ff.month_out    <= month_ff;
         out_ff.day_of_month <= cal_days_ff[4:0] + 5'd1;
         out_ff.hour_out     <= hour_ff;
         out_ff.minute_out   <= minute_ff;
         out_ff.second_out   <= second_ff;
         out_ff.weekday_out  <= wd_ff;
         out_ff.week_number  <= week_ff;
      end
   end

   assign rsp_data = out_ff;

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> ((month_ff >= 4'd1) && (month_ff <= 4'd12)))
      else $error("month out of range at publish");

   a_day_range: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (cal_days_ff < 16'd31))
      else $error("day of month out of range at publish");

   a_hour_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_capture && (cmd.op == DIV_HOUR)) |-> (quo_ff < 16'd24))
      else $error("hour quotient out of range");

endmodule
